[design/complex_number_alu_core_macros.svh]
// Assertion macros for the complex-number ALU core.
// Used by complex_number_alu_core.sv; no other dependencies.
`ifndef COMPLEX_NUMBER_ALU_CORE_MACROS_SVH
`define COMPLEX_NUMBER_ALU_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CNA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CNA_ASSERT(lbl, prop, msg) `CNA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CNA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CNA_ASSERT(lbl, prop, msg)
`endif
`endif

[design/cna_pkg.sv]
// Shared types and defaults for the complex-number ALU core.
// No dependencies.
package cna_pkg;

  localparam int PART_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Per-item control that rides along the pipeline.
  typedef struct packed {
    opcode_e op;
    status_e status;
    logic    cmp;
  } cna_meta_t;

endpackage

[design/cna_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// Depends on cna_pkg.
module cna_div_pipe
  import cna_pkg::*;
#(
  parameter int PartWidth    = PART_WIDTH_DEF,
  parameter int FractionBits = FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  cna_meta_t                  meta_i,
  input  logic [2*PartWidth-1:0]     side_i,
  input  logic [2*PartWidth+FractionBits:0] num_re_i,
  input  logic [2*PartWidth+FractionBits:0] num_im_i,
  input  logic                       neg_re_i,
  input  logic                       neg_im_i,
  input  logic [2*PartWidth-1:0]     den_i,
  output logic                       valid_o,
  output cna_meta_t                  meta_o,
  output logic [2*PartWidth-1:0]     side_o,
  output logic [PartWidth-1:0]       q_re_o,
  output logic [PartWidth-1:0]       q_im_o,
  output logic                       ovf_re_o,
  output logic                       ovf_im_o,
  output logic                       neg_re_o,
  output logic                       neg_im_o
);

  localparam int W  = PartWidth;
  localparam int NW = 2*W + FractionBits + 1;
  localparam int CW = 3*W + FractionBits + 2;

  logic            vld_q  [W];
  cna_meta_t       meta_q [W];
  logic [2*W-1:0]  side_q [W];
  logic [NW-1:0]   rre_q  [W];
  logic [NW-1:0]   rim_q  [W];
  logic [W-1:0]    qre_q  [W];
  logic [W-1:0]    qim_q  [W];
  logic [2*W-1:0]  den_q  [W];
  logic            ovre_q [W];
  logic            ovim_q [W];
  logic            ngre_q [W];
  logic            ngim_q [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int K = W - 1 - s;

    logic            vld_in, ovre_in, ovim_in, ngre_in, ngim_in;
    cna_meta_t       meta_in;
    logic [2*W-1:0]  side_in, den_in;
    logic [NW-1:0]   rre_in, rim_in, rre_d, rim_d;
    logic [W-1:0]    qre_in, qim_in, qre_d, qim_d;
    logic [CW-1:0]   dsh;
    logic            gre, gim;

    if (s == 0) begin : g_first
      // overflow when |num| >= den * 2^W: quotient does not fit the lane
      assign ovre_in = CW'(num_re_i) >= (CW'(den_i) << W);
      assign ovim_in = CW'(num_im_i) >= (CW'(den_i) << W);
      assign vld_in  = valid_i;
      assign meta_in = meta_i;
      assign side_in = side_i;
      assign den_in  = den_i;
      assign rre_in  = num_re_i;
      assign rim_in  = num_im_i;
      assign qre_in  = '0;
      assign qim_in  = '0;
      assign ngre_in = neg_re_i;
      assign ngim_in = neg_im_i;
    end else begin : g_next
      assign ovre_in = ovre_q[s-1];
      assign ovim_in = ovim_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign meta_in = meta_q[s-1];
      assign side_in = side_q[s-1];
      assign den_in  = den_q[s-1];
      assign rre_in  = rre_q[s-1];
      assign rim_in  = rim_q[s-1];
      assign qre_in  = qre_q[s-1];
      assign qim_in  = qim_q[s-1];
      assign ngre_in = ngre_q[s-1];
      assign ngim_in = ngim_q[s-1];
    end

    assign dsh   = CW'(den_in) << K;
    assign gre   = CW'(rre_in) >= dsh;
    assign gim   = CW'(rim_in) >= dsh;
    assign rre_d = gre ? NW'(CW'(rre_in) - dsh) : rre_in;
    assign rim_d = gim ? NW'(CW'(rim_in) - dsh) : rim_in;
    assign qre_d = qre_in | (gre ? (W'(1) << K) : '0);
    assign qim_d = qim_in | (gim ? (W'(1) << K) : '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        meta_q[s] <= meta_in;
        side_q[s] <= side_in;
        den_q[s]  <= den_in;
        rre_q[s]  <= rre_d;
        rim_q[s]  <= rim_d;
        qre_q[s]  <= qre_d;
        qim_q[s]  <= qim_d;
        ovre_q[s] <= ovre_in;
        ovim_q[s] <= ovim_in;
        ngre_q[s] <= ngre_in;
        ngim_q[s] <= ngim_in;
      end
    end
  end

  assign valid_o  = vld_q[W-1];
  assign meta_o   = meta_q[W-1];
  assign side_o   = side_q[W-1];
  assign q_re_o   = qre_q[W-1];
  assign q_im_o   = qim_q[W-1];
  assign ovf_re_o = ovre_q[W-1];
  assign ovf_im_o = ovim_q[W-1];
  assign neg_re_o = ngre_q[W-1];
  assign neg_im_o = ngim_q[W-1];

endmodule

[design/complex_number_alu_core.sv]
// Complex-number ALU core: pipelined add/sub/mul/div/compare on Q-format parts.
// Depends on cna_pkg, cna_div_pipe and complex_number_alu_core_macros.svh.
//
// Usage:
//   Input channel: valid_i / stall_o carry opcode_i and operands A = a_re_i + a_im_i*i,
//   B = b_re_i + b_im_i*i. A transfer happens on a clock edge with valid_i high and
//   stall_o low. Output channel: valid_o / stall_i carry res_re_o, res_im_o,
//   compare_true_o and status_o (0 ok, 1 saturated, 2 divide by zero).
//   Throughput: one transfer per cycle on both sides while no held result stalls the pipe.
//   Every opcode takes the same path through all stages, so results keep input order.
//   The depth is set by the divider, which resolves one quotient bit per stage.
//   Stall: the output register holds its result while stall_i is high; the whole
//   pipe freezes and stall_o rises only while a held result is waiting, so nothing
//   is dropped or repeated. Bubbles in flight still move into the output slot.
//   Reset (rst_ni low, async) empties every stage; no other state exists.
//   Multiply rounds toward minus infinity, divide truncates toward zero, and results
//   out of range saturate. Unused opcodes return all zeros.
`include "complex_number_alu_core_macros.svh"
module complex_number_alu_core
  import cna_pkg::*;
#(
  parameter int PartWidth    = PART_WIDTH_DEF,
  parameter int FractionBits = FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [2:0]                  opcode_i,
  input  logic signed [PartWidth-1:0] a_re_i,
  input  logic signed [PartWidth-1:0] a_im_i,
  input  logic signed [PartWidth-1:0] b_re_i,
  input  logic signed [PartWidth-1:0] b_im_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [PartWidth-1:0] res_re_o,
  output logic signed [PartWidth-1:0] res_im_o,
  output logic                        compare_true_o,
  output logic [1:0]                  status_o
);

  localparam int W  = PartWidth;
  localparam int F  = FractionBits;
  localparam int XW = 2*W + 1;      // exact sum of two products
  localparam int NW = 2*W + F + 1;  // dividend magnitude after fraction shift
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // Whole pipe advances unless a finished result is held by the receiver.
  logic adv;
  logic out_valid_q;
  assign adv     = !(out_valid_q && stall_i);
  assign stall_o = !adv;

  // Clamp an exact value to the part range; MSB of the result flags saturation.
  function automatic logic [W:0] sat_x(input logic signed [XW-1:0] x);
    logic [W+1:0] top;
    top = x[XW-1:W-1];
    if (&top || ~|top) return {1'b0, x[W-1:0]};
    else if (x[XW-1])  return {1'b1, MINV};
    else               return {1'b1, MAXV};
  endfunction

  // Apply the sign to an unsigned quotient and clamp it.
  function automatic logic [W:0] div_fin(input logic [W-1:0] q, input logic ovf,
                                         input logic neg);
    if (neg) begin
      if (ovf || q > MINV) return {1'b1, MINV};
      else                 return {1'b0, W'(~q + W'(1))};
    end else begin
      if (ovf || q[W-1])   return {1'b1, MAXV};
      else                 return {1'b0, q};
    end
  endfunction

  // ---------------- stage 1: input register ----------------
  logic                v1_q;
  opcode_e             op1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= opcode_e'(opcode_i);
      ar1_q <= a_re_i;
      ai1_q <= a_im_i;
      br1_q <= b_re_i;
      bi1_q <= b_im_i;
    end
  end

  // ---------------- stage 2: products, add/sub, equality ----------------
  logic signed [2*W-1:0] ac_d, bd_d, ad_d, bc_d, cc_d, dd_d;
  logic signed [W:0]     asre_d, asim_d;

  assign ac_d = ar1_q * br1_q;
  assign bd_d = ai1_q * bi1_q;
  assign ad_d = ar1_q * bi1_q;
  assign bc_d = ai1_q * br1_q;
  assign cc_d = br1_q * br1_q;
  assign dd_d = bi1_q * bi1_q;

  always_comb begin
    if (op1_q == OP_SUB) begin
      asre_d = (W+1)'(ar1_q) - (W+1)'(br1_q);
      asim_d = (W+1)'(ai1_q) - (W+1)'(bi1_q);
    end else begin
      asre_d = (W+1)'(ar1_q) + (W+1)'(br1_q);
      asim_d = (W+1)'(ai1_q) + (W+1)'(bi1_q);
    end
  end

  logic                  v2_q, eq2_q;
  opcode_e               op2_q;
  logic signed [2*W-1:0] ac2_q, bd2_q, ad2_q, bc2_q, cc2_q, dd2_q;
  logic signed [W:0]     asre2_q, asim2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q   <= op1_q;
      eq2_q   <= (ar1_q == br1_q) && (ai1_q == bi1_q);
      ac2_q   <= ac_d;
      bd2_q   <= bd_d;
      ad2_q   <= ad_d;
      bc2_q   <= bc_d;
      cc2_q   <= cc_d;
      dd2_q   <= dd_d;
      asre2_q <= asre_d;
      asim2_q <= asim_d;
    end
  end

  // ---------------- stage 3: product sums ----------------
  logic signed [XW-1:0] mre_d, mim_d, xre_d, xim_d, nr_d, ni_d;
  logic [2*W-1:0]       den_d;

  assign mre_d = XW'(ac2_q) - XW'(bd2_q);
  assign mim_d = XW'(ad2_q) + XW'(bc2_q);
  assign nr_d  = XW'(ac2_q) + XW'(bd2_q);
  assign ni_d  = XW'(bc2_q) - XW'(ad2_q);
  assign den_d = $unsigned(cc2_q) + $unsigned(dd2_q);

  always_comb begin
    if (op2_q == OP_MUL) begin
      xre_d = mre_d >>> F;
      xim_d = mim_d >>> F;
    end else begin
      xre_d = XW'(asre2_q);
      xim_d = XW'(asim2_q);
    end
  end

  logic                 v3_q, eq3_q;
  opcode_e              op3_q;
  logic signed [XW-1:0] xre3_q, xim3_q, nr3_q, ni3_q;
  logic [2*W-1:0]       den3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op3_q  <= op2_q;
      eq3_q  <= eq2_q;
      xre3_q <= xre_d;
      xim3_q <= xim_d;
      nr3_q  <= nr_d;
      ni3_q  <= ni_d;
      den3_q <= den_d;
    end
  end

  // ---------------- stage 4: clamp, result select, dividend prep ----------------
  logic [W:0]      sre_d, sim_d;
  cna_meta_t       meta4_d;
  logic [2*W-1:0]  side4_d;
  logic [XW-1:0]   mgre_d, mgim_d;

  assign sre_d  = sat_x(xre3_q);
  assign sim_d  = sat_x(xim3_q);
  assign mgre_d = nr3_q[XW-1] ? XW'(-nr3_q) : XW'(nr3_q);
  assign mgim_d = ni3_q[XW-1] ? XW'(-ni3_q) : XW'(ni3_q);

  always_comb begin
    meta4_d.op     = op3_q;
    meta4_d.status = ST_OK;
    meta4_d.cmp    = 1'b0;
    side4_d        = '0;
    case (op3_q)
      OP_ADD, OP_SUB, OP_MUL: begin
        meta4_d.status = (sre_d[W] || sim_d[W]) ? ST_SAT : ST_OK;
        side4_d        = {sre_d[W-1:0], sim_d[W-1:0]};
      end
      OP_DIV: begin
        meta4_d.status = (den3_q == '0) ? ST_DIV0 : ST_OK;
      end
      OP_EQ: begin
        meta4_d.cmp = eq3_q;
      end
      OP_NE: begin
        meta4_d.cmp = !eq3_q;
      end
      default: begin
        meta4_d.status = ST_OK;
      end
    endcase
  end

  logic            v4_q, ngre4_q, ngim4_q;
  cna_meta_t       meta4_q;
  logic [2*W-1:0]  side4_q, den4_q;
  logic [NW-1:0]   nmre4_q, nmim4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta4_q <= meta4_d;
      side4_q <= side4_d;
      den4_q  <= den3_q;
      nmre4_q <= NW'(mgre_d) << F;
      nmim4_q <= NW'(mgim_d) << F;
      ngre4_q <= nr3_q[XW-1];
      ngim4_q <= ni3_q[XW-1];
    end
  end

  // ---------------- divider: W stages, one quotient bit each ----------------
  logic            dv, dovre, dovim, dngre, dngim;
  cna_meta_t       dmeta;
  logic [2*W-1:0]  dside;
  logic [W-1:0]    dqre, dqim;

  cna_div_pipe #(
    .PartWidth   (PartWidth),
    .FractionBits(FractionBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v4_q),
    .meta_i  (meta4_q),
    .side_i  (side4_q),
    .num_re_i(nmre4_q),
    .num_im_i(nmim4_q),
    .neg_re_i(ngre4_q),
    .neg_im_i(ngim4_q),
    .den_i   (den4_q),
    .valid_o (dv),
    .meta_o  (dmeta),
    .side_o  (dside),
    .q_re_o  (dqre),
    .q_im_o  (dqim),
    .ovf_re_o(dovre),
    .ovf_im_o(dovim),
    .neg_re_o(dngre),
    .neg_im_o(dngim)
  );

  // ---------------- output register ----------------
  logic [W:0]     fre, fim;
  logic [W-1:0]   ore_d, oim_d;
  status_e        ost_d;

  assign fre = div_fin(dqre, dovre, dngre);
  assign fim = div_fin(dqim, dovim, dngim);

  always_comb begin
    if (dmeta.op == OP_DIV && dmeta.status != ST_DIV0) begin
      ore_d = fre[W-1:0];
      oim_d = fim[W-1:0];
      ost_d = (fre[W] || fim[W]) ? ST_SAT : ST_OK;
    end else begin
      ore_d = dside[2*W-1:W];
      oim_d = dside[W-1:0];
      ost_d = dmeta.status;
    end
  end

  logic           cmp_q;
  logic [W-1:0]   res_re_q, res_im_q;
  status_e        status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_q <= ore_d;
      res_im_q <= oim_d;
      cmp_q    <= dmeta.cmp;
      status_q <= ost_d;
    end
  end

  assign valid_o        = out_valid_q;
  assign res_re_o       = res_re_q;
  assign res_im_o       = res_im_q;
  assign compare_true_o = cmp_q;
  assign status_o       = status_q;

  // ---------------- checks ----------------
  `CNA_ASSERT(a_div0_zero, valid_o && status_o == ST_DIV0 |-> res_re_o == '0 && res_im_o == '0, "divide by zero with nonzero result")
  `CNA_ASSERT(a_cmp_clean, valid_o && compare_true_o |-> status_o == ST_OK && res_re_o == '0 && res_im_o == '0, "compare result carries arithmetic data")
  `CNA_ASSERT(a_sat_extreme, valid_o && status_o == ST_SAT |-> res_re_o == MAXV || res_re_o == MINV || res_im_o == MAXV || res_im_o == MINV, "saturation flagged without clamped part")

endmodule
